[rtl/mrbm_pkg.sv]
// Shared types and constants for the maximal rectangle unit.
package mrbm_pkg;

   localparam int unsigned CFG_W = 7;
   localparam int unsigned AREA_W = 13;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
   localparam logic [AREA_W-1:0] AREA_CAP = 13'd8191;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_POPCHK,
      ST_PUSH,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic latch;
      logic calc;
      logic pop;
      logic flush;
      logic push;
      logic note_pushed;
      logic col_adv;
      logic col_clear;
      logic rsp_load;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic pop_cond;
      logic depth_zero;
      logic depth_one;
      logic row_end;
      logic last;
      logic clear_done;
      logic rsp_busy;
   } status_type;

endpackage

[rtl/maximal_rectangle_binary_matrix_unit.sv]
// Maximal all-ones rectangle unit: top level joining controller and datapath.
//
// Cells of a binary matrix arrive row-major, one per item, with the row length
// taken from csr_columns_in_use (0 acts as 1, values above MAX_COLS act as
// MAX_COLS). Each cell updates its column's run height and runs one step of
// the largest-rectangle-in-histogram stack scan. A cell is latched, its height
// is updated, each stack comparison that pops a bar repeats the compare step,
// and the cell's bar is then pushed; pops average at most one per cell. The
// last cell of a row scores its bar and flushes every bar left on the stack.
// The cell flagged req_last_cell ends its row, loads the best area into the
// output register, and is followed by a clearing pass over the height memory;
// the same pass runs after reset. No cell is taken during the pass;
// configuration writes are.
module maximal_rectangle_binary_matrix_unit #(
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned MAX_ROWS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [mrbm_pkg::CFG_W-1:0]   csr_columns_in_use,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cell_bit,
   input  logic                         req_last_cell,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mrbm_pkg::AREA_W-1:0]  rsp_max_area
);

   mrbm_pkg::cmd_type    cmd;
   mrbm_pkg::status_type status;

   mrbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrbm_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_columns_in_use (csr_columns_in_use),
      .req_cell_bit       (req_cell_bit),
      .req_last_cell      (req_last_cell),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_max_area       (rsp_max_area),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

[rtl/mrbm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mrbm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mrbm_ctrl.sv]
// Sequencer for the height update, stack scan, row flush and matrix cleanup.
module mrbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mrbm_pkg::status_type  status,
   output mrbm_pkg::cmd_type     cmd
);

   mrbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrbm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         mrbm_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_done) begin
               state_in = mrbm_pkg::ST_IDLE;
            end
         end
         mrbm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = mrbm_pkg::ST_CALC;
            end
         end
         mrbm_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = status.depth_zero ? mrbm_pkg::ST_PUSH : mrbm_pkg::ST_POPCHK;
         end
         mrbm_pkg::ST_POPCHK: begin
            if (status.pop_cond) begin
               cmd.pop = 1'b1;
               if (status.depth_one) begin
                  state_in = mrbm_pkg::ST_PUSH;
               end
            end else begin
               state_in = mrbm_pkg::ST_PUSH;
            end
         end
         mrbm_pkg::ST_PUSH: begin
            if (!status.row_end) begin
               cmd.push = 1'b1;
               cmd.col_adv = 1'b1;
               state_in = mrbm_pkg::ST_IDLE;
            end else begin
               // row end: score the new bar directly instead of pushing it
               cmd.note_pushed = 1'b1;
               if (status.depth_zero) begin
                  cmd.col_clear = 1'b1;
                  state_in = status.last ? mrbm_pkg::ST_DRAIN : mrbm_pkg::ST_IDLE;
               end else begin
                  state_in = mrbm_pkg::ST_FLUSH;
               end
            end
         end
         mrbm_pkg::ST_FLUSH: begin
            cmd.pop = 1'b1;
            cmd.flush = 1'b1;
            if (status.depth_one) begin
               cmd.col_clear = 1'b1;
               state_in = status.last ? mrbm_pkg::ST_DRAIN : mrbm_pkg::ST_IDLE;
            end
         end
         mrbm_pkg::ST_DRAIN: begin
            // hold until the output register is free, then reload it
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = mrbm_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = mrbm_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

[rtl/mrbm_dp.sv]
// Datapath: height store, stack store, area scoring and result register.
module mrbm_dp #(
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned MAX_ROWS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mrbm_pkg::CFG_W-1:0]        csr_columns_in_use,
   input  logic                              req_cell_bit,
   input  logic                              req_last_cell,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mrbm_pkg::AREA_W-1:0]       rsp_max_area,
   input  mrbm_pkg::cmd_type                 cmd,
   output mrbm_pkg::status_type              status
);

   localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned DW = $clog2(MAX_COLS + 1);
   localparam int unsigned HW = $clog2(MAX_ROWS + 1);
   localparam int unsigned PW = HW + DW;
   localparam int unsigned SW = (PW > mrbm_pkg::AREA_W) ? PW : mrbm_pkg::AREA_W;
   localparam int unsigned CMPW = (DW > mrbm_pkg::CFG_W) ? DW : mrbm_pkg::CFG_W;

   logic [mrbm_pkg::CFG_W-1:0] cfg_ff;
   logic                       cell_ff;
   logic                       last_ff;
   logic [AW-1:0]              col_ff;
   logic [DW-1:0]              depth_ff;
   logic [HW-1:0]              h_ff;
   logic [AW-1:0]              start_ff;
   logic [AW-1:0]              clr_ff;
   logic [PW-1:0]              prod_ff;
   logic                       prod_vld_ff;
   logic [mrbm_pkg::AREA_W-1:0] best_ff;
   logic                       rsp_valid_ff;
   logic [mrbm_pkg::AREA_W-1:0] rsp_data_ff;

   logic [HW-1:0]              hrd;
   logic [HW-1:0]              h_in;
   logic                       h_we;
   logic [AW-1:0]              h_waddr;
   logic [HW-1:0]              h_wdata;
   logic [AW+HW-1:0]           srd;
   logic [AW-1:0]              srd_start;
   logic [HW-1:0]              srd_h;
   logic [DW-1:0]              s_raddr_full;
   logic [AW-1:0]              s_raddr;
   logic [CMPW-1:0]            cols_eff;
   logic [CMPW-1:0]            col_next;
   logic [DW-1:0]              width_end;
   logic [HW-1:0]              note_h;
   logic [DW-1:0]              note_w;
   logic [SW-1:0]              prod_ext;
   logic [mrbm_pkg::AREA_W-1:0] area_sat;
   logic [mrbm_pkg::AREA_W-1:0] best_in;

   // run height store
   mrbm_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_heights (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (col_ff),
      .rd_data (hrd)
   );

   // stack of (start column, height)
   mrbm_ram #(.WIDTH(AW + HW), .DEPTH(MAX_COLS)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data ({start_ff, h_ff}),
      .rd_addr (s_raddr),
      .rd_data (srd)
   );

   assign srd_start = srd[AW+HW-1:HW];
   assign srd_h = srd[HW-1:0];

   // a pop this cycle means the next top sits two below the current count
   assign s_raddr_full = cmd.pop ? (depth_ff - DW'(2)) : (depth_ff - DW'(1));
   assign s_raddr = s_raddr_full[AW-1:0];

   always_comb begin
      if (cell_ff) begin
         h_in = (hrd < HW'(MAX_ROWS)) ? (hrd + HW'(1)) : HW'(MAX_ROWS);
      end else begin
         h_in = '0;
      end
      h_we = cmd.calc | cmd.clr_step;
      h_waddr = cmd.clr_step ? clr_ff : col_ff;
      h_wdata = cmd.clr_step ? '0 : h_in;
   end

   always_comb begin
      if (cfg_ff == '0) begin
         cols_eff = CMPW'(1);
      end else if (CMPW'(cfg_ff) > CMPW'(MAX_COLS)) begin
         cols_eff = CMPW'(MAX_COLS);
      end else begin
         cols_eff = CMPW'(cfg_ff);
      end
      col_next = CMPW'(col_ff) + CMPW'(1);
      width_end = DW'(col_ff) + DW'(1);
   end

   always_comb begin
      status.pop_cond = srd_h > h_ff;
      status.depth_zero = depth_ff == '0;
      status.depth_one = depth_ff == DW'(1);
      status.row_end = last_ff | (col_next >= cols_eff);
      status.last = last_ff;
      status.clear_done = clr_ff == AW'(MAX_COLS - 1);
      status.rsp_busy = rsp_valid_ff & ~rsp_ready;
   end

   // area scoring: the product is registered, then saturated and compared in the next cycle
   always_comb begin
      if (cmd.note_pushed) begin
         note_h = h_ff;
         note_w = width_end - DW'(start_ff);
      end else if (cmd.flush) begin
         note_h = srd_h;
         note_w = width_end - DW'(srd_start);
      end else begin
         // a bar popped by a shorter one ends just before the current column
         note_h = srd_h;
         note_w = DW'(col_ff) - DW'(srd_start);
      end
      prod_ext = SW'(prod_ff);
      area_sat = (prod_ext > SW'(mrbm_pkg::AREA_CAP)) ? mrbm_pkg::AREA_CAP
                                                      : prod_ext[mrbm_pkg::AREA_W-1:0];
      best_in = best_ff;
      if (prod_vld_ff && (area_sat > best_ff)) begin
         best_in = area_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mrbm_pkg::CFG_RESET;
         col_ff <= '0;
         depth_ff <= '0;
         clr_ff <= '0;
         prod_vld_ff <= 1'b0;
         best_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_columns_in_use;
         end
         if (cmd.col_adv) begin
            col_ff <= col_ff + AW'(1);
         end else if (cmd.col_clear) begin
            col_ff <= '0;
         end
         if (cmd.push) begin
            depth_ff <= depth_ff + DW'(1);
         end else if (cmd.pop) begin
            depth_ff <= depth_ff - DW'(1);
         end
         if (cmd.clr_step) begin
            clr_ff <= status.clear_done ? '0 : (clr_ff + AW'(1));
         end
         prod_vld_ff <= cmd.pop | cmd.note_pushed;
         best_ff <= cmd.rsp_load ? '0 : best_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cell_ff <= req_cell_bit;
         last_ff <= req_last_cell;
      end
      if (cmd.calc) begin
         h_ff <= h_in;
         start_ff <= col_ff;
      end else if (cmd.pop) begin
         // carry the popped bar's start column into the new bar
         start_ff <= srd_start;
      end
      prod_ff <= PW'(note_h) * PW'(note_w);
      if (cmd.rsp_load) begin
         rsp_data_ff <= best_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_max_area = rsp_data_ff;

endmodule
